>>> rtl/bls_pkg.sv
// Shared types and constants for the bounded LIFO stack.
package bls_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int C_IDX_W    = $clog2(DEPTH);
    localparam int C_CNT_W    = 7;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [C_CNT_W-1:0]           t_count;
    typedef logic [C_IDX_W-1:0]           t_index;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_PEEK   = 3'd2,
        ACT_TOP    = 3'd3,
        ACT_BOTTOM = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BADPOS   = 2'd3
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

    localparam t_count C_CAP_RESET = t_count'(DEPTH);

endpackage

>>> rtl/bls_if.sv
// Handshake channels of the bounded LIFO stack: request, result and capacity write.
interface bls_in_if;
    import bls_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    t_data       push_value;
    t_count      position;
    modport source (output valid, output action, output push_value, output position,
                    input ready);
    modport sink   (input valid, input action, input push_value, input position,
                    output ready);
endinterface

interface bls_out_if;
    import bls_pkg::*;
    logic        valid;
    logic        ready;
    t_data       read_data;
    logic [1:0]  status;
    t_count      entry_count;
    modport source (output valid, output read_data, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_data, input status, input entry_count,
                    output ready);
endinterface

interface bls_cfg_if;
    import bls_pkg::*;
    logic        valid;
    logic        ready;
    t_count      data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/bounded_lifo_stack.sv
// Bounded LIFO stack built from a row of shifting cells, top entry in cell 0.
// The result is registered and is valid in the cycle after the request beat is accepted.
// Throughput: one request per cycle; the output register stalls only on back-pressure.
// Every cell moves in the same cycle on a push or a pop.
// Reset: fill count 0, capacity 64, no result pending; cell contents undefined.
module bounded_lifo_stack (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bls_in_if.sink    i_in,
    bls_out_if.source o_out,
    bls_cfg_if.sink   i_cfg
);
    import bls_pkg::*;

    t_data      w_cells [DEPTH];
    t_shift_ctl w_ctl;

    t_count  r_capacity;
    t_count  r_fill;
    t_count  n_fill;
    t_count  w_eff_cap;
    logic    w_accept;
    logic    r_out_valid;
    t_data   r_read_data;
    t_status r_status;
    t_count  r_entry_count;
    t_data   n_read_data;
    t_status n_status;
    t_index  w_rd_idx;
    t_data   w_rd_word;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;

    always_comb begin
        w_eff_cap = r_capacity;
        if (r_capacity == '0) begin
            w_eff_cap = t_count'(1);
        end else if (r_capacity > t_count'(DEPTH)) begin
            w_eff_cap = t_count'(DEPTH);
        end
    end

    // peek reads position-1 below the top, bottom reads fill-1
    always_comb begin
        t_count idx_full;
        if (i_in.action == ACT_PEEK) begin
            idx_full = i_in.position - t_count'(1);
        end else begin
            idx_full = r_fill - t_count'(1);
        end
        w_rd_idx  = idx_full[C_IDX_W-1:0];
        w_rd_word = w_cells[w_rd_idx];
    end

    always_comb begin
        n_fill      = r_fill;
        n_read_data = '0;
        n_status    = ST_OK;
        w_ctl       = '0;
        case (i_in.action)
            ACT_PUSH: begin
                if (r_fill >= w_eff_cap) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    w_ctl.push = w_accept;
                    n_fill     = r_fill + t_count'(1);
                end
            end
            ACT_POP: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl.pop   = w_accept;
                    n_fill      = r_fill - t_count'(1);
                    n_read_data = w_cells[0];
                end
            end
            ACT_PEEK: begin
                if (i_in.position == '0 || i_in.position > r_fill) begin
                    n_status    = ST_BADPOS;
                    n_read_data = '1;
                end else begin
                    n_read_data = w_rd_word;
                end
            end
            ACT_TOP: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_read_data = w_cells[0];
                end
            end
            ACT_BOTTOM: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_read_data = w_rd_word;
                end
            end
            default: begin
            end
        endcase
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            t_data w_up;
            t_data w_down;
            if (k == 0) begin : g_head
                assign w_up = i_in.push_value;
            end else begin : g_mid
                assign w_up = w_cells[k-1];
            end
            if (k == DEPTH - 1) begin : g_tail
                assign w_down = w_cells[k];
            end else begin : g_body
                assign w_down = w_cells[k+1];
            end
            bls_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_from_up   (w_up),
                .i_from_down (w_down),
                .o_data      (w_cells[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= C_CAP_RESET;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_capacity <= i_cfg.data;
            end
            if (w_accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_data   <= n_read_data;
            r_status      <= n_status;
            r_entry_count <= n_fill;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_data   = r_read_data;
    assign o_out.status      = r_status;
    assign o_out.entry_count = r_entry_count;

endmodule

>>> rtl/bls_cell.sv
// One stack cell: holds a word and shifts it down on push or up on pop.
module bls_cell (
    input  logic                 i_clk,
    input  bls_pkg::t_shift_ctl  i_ctl,
    input  bls_pkg::t_data       i_from_up,
    input  bls_pkg::t_data       i_from_down,
    output bls_pkg::t_data       o_data
);
    import bls_pkg::*;

    t_data r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_data <= i_from_up;
        end else if (i_ctl.pop) begin
            r_data <= i_from_down;
        end
    end

    assign o_data = r_data;

endmodule
